### rtl/esp_pkg.sv
package esp_pkg;

   localparam int TIME_WIDTH_DEF = 32;
   localparam int COUNT_W        = 32;
   localparam int SPEED_W        = 24;
   localparam int DEBOUNCE_W     = 10;
   localparam int PPR_W          = 13;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 13;
   localparam int QUEUE_DEPTH    = 4;

   // numerator dp * 15360000 stays below 2^56
   localparam int NUM_W          = 56;
   localparam int QUOT_W         = 24;
   localparam int PROD_W         = 48;
   localparam int DECAY_SHIFT    = 26;
   localparam int MIN_SAMPLE_MS  = 10;

   localparam logic [SPEED_W-1:0]    RATE_NUM    = 24'd15360000;
   localparam logic [SPEED_W-1:0]    RAMP_Q8     = 24'd2560;
   localparam logic [SPEED_W-1:0]    FLOOR_Q8    = 24'd25;
   localparam logic [SPEED_W-1:0]    SPEED_MAX   = 24'hFFFFFF;
   // ceil(2^26 / 5), exact floor division by 5 for 24 bit values
   localparam logic [SPEED_W-1:0]    DECAY_RECIP = 24'd13421773;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd5;
   localparam logic [PPR_W-1:0]      PPR_RESET      = 13'd20;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PPR      = 2'd1;

   typedef enum logic [1:0] {
      CMD_PASS    = 2'd0,
      CMD_MEASURE = 2'd1,
      CMD_DECAY   = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      logic busy;
      logic dividing;
   } back_status_type;

endpackage

### rtl/esp_queue.sv
module esp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/esp_front.sv
module esp_front #(
   parameter int TIME_WIDTH = esp_pkg::TIME_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic                            req_mode,
   input  logic [31:0]                     req_time_ms,
   input  logic [esp_pkg::DEBOUNCE_W-1:0]  debounce,
   input  logic                            q_full,
   output logic                            q_push,
   output esp_pkg::cmd_kind_type           cmd_kind,
   output logic [esp_pkg::COUNT_W-1:0]     cmd_total,
   output logic [esp_pkg::COUNT_W-1:0]     cmd_dp,
   output logic [TIME_WIDTH-1:0]           cmd_dt
);

   import esp_pkg::*;

   logic [TIME_WIDTH-1:0] now;
   logic [TIME_WIDTH-1:0] since;
   logic                  edge_ok;
   logic                  sample_ok;

   logic [COUNT_W-1:0]    pulse_count_ff, pulse_count_in;
   logic [TIME_WIDTH-1:0] last_edge_ff, last_edge_in;
   logic [COUNT_W-1:0]    sample_count_ff, sample_count_in;
   logic [TIME_WIDTH-1:0] sample_time_ff, sample_time_in;

   assign now       = TIME_WIDTH'(req_time_ms);
   assign since     = now - last_edge_ff;
   assign edge_ok   = since > TIME_WIDTH'(debounce);
   assign cmd_dt    = now - sample_time_ff;
   assign sample_ok = cmd_dt >= TIME_WIDTH'(MIN_SAMPLE_MS);
   assign cmd_dp    = pulse_count_ff - sample_count_ff;
   assign q_push    = push && !q_full;

   always_comb begin
      cmd_kind        = CMD_PASS;
      cmd_total       = pulse_count_ff;
      pulse_count_in  = pulse_count_ff;
      last_edge_in    = last_edge_ff;
      sample_count_in = sample_count_ff;
      sample_time_in  = sample_time_ff;
      if (!req_mode) begin
         if (edge_ok) begin
            cmd_total      = pulse_count_ff + 1'b1;
            pulse_count_in = cmd_total;
            last_edge_in   = now;
         end
      end else if (sample_ok) begin
         cmd_kind        = (cmd_dp != '0) ? CMD_MEASURE : CMD_DECAY;
         sample_count_in = pulse_count_ff;
         sample_time_in  = now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_count_ff  <= '0;
         last_edge_ff    <= '0;
         sample_count_ff <= '0;
         sample_time_ff  <= '0;
      end else if (q_push) begin
         pulse_count_ff  <= pulse_count_in;
         last_edge_ff    <= last_edge_in;
         sample_count_ff <= sample_count_in;
         sample_time_ff  <= sample_time_in;
      end
   end

endmodule

### rtl/esp_back.sv
module esp_back #(
   parameter int TIME_WIDTH = esp_pkg::TIME_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [esp_pkg::PPR_W-1:0]     ppr,
   input  logic                          head_empty,
   input  esp_pkg::cmd_kind_type         head_kind,
   input  logic [esp_pkg::COUNT_W-1:0]   head_total,
   input  logic [esp_pkg::COUNT_W-1:0]   head_dp,
   input  logic [TIME_WIDTH-1:0]         head_dt,
   output logic                          head_pop,
   input  logic                          pop,
   output logic                          empty,
   output logic [esp_pkg::COUNT_W-1:0]   rsp_pulse_total,
   output logic [esp_pkg::SPEED_W-1:0]   rsp_speed_rpm_q8,
   output logic                          rsp_speed_updated,
   output esp_pkg::back_status_type      status
);

   import esp_pkg::*;

   localparam int DEN_W = PPR_W + TIME_WIDTH;
   localparam int CMP_W = (DEN_W > NUM_W) ? DEN_W : NUM_W;
   localparam int DSH_W = NUM_W + QUOT_W;
   localparam int CNT_W = $clog2(QUOT_W);
   localparam int DEC_W = PROD_W - DECAY_SHIFT;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MUL   = 7'b0000010,
      ST_CHECK = 7'b0000100,
      ST_SAT   = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_RAMP  = 7'b0100000,
      ST_DECAY = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic                  out_valid_ff, out_valid_in;
   logic [COUNT_W-1:0]    out_total_ff, out_total_in;
   logic [SPEED_W-1:0]    out_speed_ff, out_speed_in;
   logic                  out_updated_ff, out_updated_in;
   logic [SPEED_W-1:0]    est_ff, est_in;
   logic [COUNT_W-1:0]    total_ff, total_in;
   logic [COUNT_W-1:0]    dp_ff, dp_in;
   logic [TIME_WIDTH-1:0] dt_ff, dt_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic [NUM_W-1:0]      rem_ff, rem_in;
   logic [DSH_W-1:0]      dsh_ff, dsh_in;
   logic [QUOT_W-1:0]     quot_ff, quot_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SPEED_W-1:0]    rate_ff, rate_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;

   logic                  out_taken;
   logic                  out_free;
   logic [SPEED_W:0]      ramp_up;
   logic [DEC_W-1:0]      dec_val;
   logic [SPEED_W-1:0]    ramp_est;
   logic [SPEED_W-1:0]    decay_est;

   assign out_taken = pop && out_valid_ff;
   assign out_free  = !out_valid_ff || out_taken;
   assign ramp_up   = {1'b0, est_ff} + {1'b0, RAMP_Q8};
   assign dec_val   = prod_ff[PROD_W-1:DECAY_SHIFT];

   // rising estimate is slew limited, falling one follows at once
   assign ramp_est  = (rate_ff > est_ff)
                    ? ((ramp_up > {1'b0, rate_ff}) ? rate_ff : ramp_up[SPEED_W-1:0])
                    : rate_ff;
   assign decay_est = (SPEED_W'(dec_val) <= FLOOR_Q8) ? '0 : SPEED_W'(dec_val);

   assign empty             = !out_valid_ff;
   assign rsp_pulse_total   = out_total_ff;
   assign rsp_speed_rpm_q8  = out_speed_ff;
   assign rsp_speed_updated = out_updated_ff;
   assign status.busy       = (state_ff != ST_IDLE);
   assign status.dividing   = (state_ff == ST_DIV);

   always_comb begin
      state_in       = state_ff;
      head_pop       = 1'b0;
      out_valid_in   = out_valid_ff && !out_taken;
      out_total_in   = out_total_ff;
      out_speed_in   = out_speed_ff;
      out_updated_in = out_updated_ff;
      est_in         = est_ff;
      total_in       = total_ff;
      dp_in          = dp_ff;
      dt_in          = dt_ff;
      num_in         = num_ff;
      den_in         = den_ff;
      rem_in         = rem_ff;
      dsh_in         = dsh_ff;
      quot_in        = quot_ff;
      cnt_in         = cnt_ff;
      rate_in        = rate_ff;
      prod_in        = prod_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // start only when the output register will be free
            if (!head_empty && out_free) begin
               head_pop = 1'b1;
               total_in = head_total;
               dp_in    = head_dp;
               dt_in    = head_dt;
               prod_in  = PROD_W'(est_ff) * PROD_W'(DECAY_RECIP);
               unique case (head_kind)
                  CMD_MEASURE: state_in = ST_MUL;
                  CMD_DECAY:   state_in = ST_DECAY;
                  default: begin
                     out_valid_in   = 1'b1;
                     out_total_in   = head_total;
                     out_speed_in   = est_ff;
                     out_updated_in = 1'b0;
                  end
               endcase
            end
         end
         ST_MUL: begin
            num_in   = NUM_W'(dp_ff) * NUM_W'(RATE_NUM);
            den_in   = DEN_W'(ppr) * DEN_W'(dt_ff);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (ppr == '0) begin
               rate_in  = SPEED_MAX;
               state_in = ST_RAMP;
            end else if (CMP_W'(den_ff) > CMP_W'(num_ff)) begin
               rate_in  = '0;
               state_in = ST_RAMP;
            end else begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            // den fits the numerator width here
            if (DSH_W'(num_ff) >= (DSH_W'(NUM_W'(den_ff)) << QUOT_W)) begin
               rate_in  = SPEED_MAX;
               state_in = ST_RAMP;
            end else begin
               rem_in   = num_ff;
               dsh_in   = DSH_W'(NUM_W'(den_ff)) << (QUOT_W - 1);
               quot_in  = '0;
               cnt_in   = CNT_W'(QUOT_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (DSH_W'(rem_ff) >= dsh_ff) begin
               rem_in  = rem_ff - NUM_W'(dsh_ff);
               quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
            end else begin
               quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               rate_in  = quot_in;
               state_in = ST_RAMP;
            end
         end
         ST_RAMP: begin
            est_in         = ramp_est;
            out_valid_in   = 1'b1;
            out_total_in   = total_ff;
            out_speed_in   = ramp_est;
            out_updated_in = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_DECAY: begin
            est_in         = decay_est;
            out_valid_in   = 1'b1;
            out_total_in   = total_ff;
            out_speed_in   = decay_est;
            out_updated_in = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      out_total_ff   <= out_total_in;
      out_speed_ff   <= out_speed_in;
      out_updated_ff <= out_updated_in;
      total_ff       <= total_in;
      dp_ff          <= dp_in;
      dt_ff          <= dt_in;
      num_ff         <= num_in;
      den_ff         <= den_in;
      rem_ff         <= rem_in;
      dsh_ff         <= dsh_in;
      quot_ff        <= quot_in;
      cnt_ff         <= cnt_in;
      rate_ff        <= rate_in;
      prod_ff        <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         est_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         est_ff       <= est_in;
      end
   end

endmodule

### rtl/encoder_speed_estimator.sv
// Speed estimator for one wheel encoder. Each item is an encoder edge
// (req_mode 0) or a speed sample (req_mode 1) with a millisecond timestamp,
// and each item gives exactly one result in order. The front end debounces
// edges, keeps the pulse count and sample timing, and takes one item per
// cycle while its four entry queue has room. Edge items and samples that come
// within 10 ms of the last one go from the queue head straight into the result
// register; a sample with no new pulses passes through the decay state first.
// A measured sample passes through the back end after it leaves the queue:
// the two products, two range checks (which may end early with a zero or
// saturated rate), the restoring divider (one quotient bit per cycle) and
// the ramp update, so the measured sample sets the sustained rate. Registers
// (index 0 debounce_ms, index 1 pulses_per_rev) are written through the csr
// port, which is always ready; write them only while the block is idle.
module encoder_speed_estimator #(
   parameter int TIME_WIDTH = esp_pkg::TIME_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic                              req_mode,
   input  logic [31:0]                       req_time_ms,
   output logic                              empty,
   input  logic                              pop,
   output logic [esp_pkg::COUNT_W-1:0]       rsp_pulse_total,
   output logic [esp_pkg::SPEED_W-1:0]       rsp_speed_rpm_q8,
   output logic                              rsp_speed_updated,
   input  logic                              valid,
   output logic                              ready,
   input  logic [esp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [esp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import esp_pkg::*;

   localparam int QW = 2 + COUNT_W + COUNT_W + TIME_WIDTH;

   logic [DEBOUNCE_W-1:0] debounce_ff, debounce_in;
   logic [PPR_W-1:0]      ppr_ff, ppr_in;

   logic                  q_push;
   logic                  q_pop;
   logic                  q_full;
   logic                  q_empty;
   logic [QW-1:0]         q_wdata;
   logic [QW-1:0]         q_rdata;

   cmd_kind_type          cmd_kind;
   logic [COUNT_W-1:0]    cmd_total;
   logic [COUNT_W-1:0]    cmd_dp;
   logic [TIME_WIDTH-1:0] cmd_dt;

   cmd_kind_type          head_kind;
   logic [COUNT_W-1:0]    head_total;
   logic [COUNT_W-1:0]    head_dp;
   logic [TIME_WIDTH-1:0] head_dt;

   back_status_type       back_status;

   assign ready = 1'b1;
   assign full  = q_full;

   always_comb begin
      debounce_in = debounce_ff;
      ppr_in      = ppr_ff;
      if (valid) begin
         unique case (csr_index)
            CSR_DEBOUNCE: debounce_in = csr_wdata[DEBOUNCE_W-1:0];
            CSR_PPR:      ppr_in      = csr_wdata[PPR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         ppr_ff      <= PPR_RESET;
      end else begin
         debounce_ff <= debounce_in;
         ppr_ff      <= ppr_in;
      end
   end

   esp_front #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_mode    (req_mode),
      .req_time_ms (req_time_ms),
      .debounce    (debounce_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .cmd_kind    (cmd_kind),
      .cmd_total   (cmd_total),
      .cmd_dp      (cmd_dp),
      .cmd_dt      (cmd_dt)
   );

   assign q_wdata = {cmd_kind, cmd_total, cmd_dp, cmd_dt};

   esp_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   assign head_kind  = cmd_kind_type'(q_rdata[QW-1 -: 2]);
   assign head_total = q_rdata[QW-3 -: COUNT_W];
   assign head_dp    = q_rdata[TIME_WIDTH+COUNT_W-1 -: COUNT_W];
   assign head_dt    = q_rdata[TIME_WIDTH-1:0];

   esp_back #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .ppr               (ppr_ff),
      .head_empty        (q_empty),
      .head_kind         (head_kind),
      .head_total        (head_total),
      .head_dp           (head_dp),
      .head_dt           (head_dt),
      .head_pop          (q_pop),
      .pop               (pop),
      .empty             (empty),
      .rsp_pulse_total   (rsp_pulse_total),
      .rsp_speed_rpm_q8  (rsp_speed_rpm_q8),
      .rsp_speed_updated (rsp_speed_updated),
      .status            (back_status)
   );

   // a sample in progress owns the result register until it finishes
   a_busy_out_free: assert property (@(posedge clock) disable iff (reset)
      back_status.busy |-> empty)
      else $error("back end busy while a result is still held");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

   a_div_ppr: assert property (@(posedge clock) disable iff (reset)
      back_status.dividing |-> (ppr_ff != '0))
      else $error("divider running with zero pulses per revolution");

endmodule
